// ===== rtl/core/dtds_pkg.sv =====
// ----------------------------------------------------------------------------
// Dataflow task scheduler package
// Command codes, field widths and storage entry formats shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package dtds_pkg;

  localparam int ID_W     = 24;
  localparam int FANIN_W  = 16;
  localparam int LINK_W   = 13;
  localparam int CFGIDX_W = 2;
  localparam int CFG_W    = 24;
  localparam int CNTOUT_W = 13;

  // Largest slot width that the window mask honors.
  localparam logic [3:0] MAX_SLOT_BITS = 4'd14;
  // Masked ids stay below this bound before they are folded into the window.
  localparam int MASKED_SPAN = 16384;
  localparam int MASKED_W    = 14;

  localparam logic [2:0] CMD_LOAD_TASK = 3'd0;
  localparam logic [2:0] CMD_LOAD_DEP  = 3'd1;
  localparam logic [2:0] CMD_START     = 3'd2;
  localparam logic [2:0] CMD_COMPLETE  = 3'd3;
  localparam logic [2:0] CMD_DISPATCH  = 3'd4;

  localparam logic [CFGIDX_W-1:0] REG_TASK_TOTAL  = 2'd0;
  localparam logic [CFGIDX_W-1:0] REG_SLOT_BITS   = 2'd1;
  localparam logic [CFGIDX_W-1:0] REG_GRAPH_BUILT = 2'd2;

  localparam logic KIND_CUBE   = 1'b0;
  localparam logic KIND_VECTOR = 1'b1;

  typedef struct packed {
    logic [FANIN_W-1:0] fanin;
    logic               kind;
    logic [LINK_W-1:0]  head;
  } task_desc_t;

  typedef struct packed {
    logic [ID_W-1:0]   consumer;
    logic [LINK_W-1:0] next;
  } dep_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/dtds_slot_unit.sv =====
// ----------------------------------------------------------------------------
// Slot reduction unit
// Masks a task id to the configured slot width and folds it into the window
// by restoring subtraction, one compare and subtract per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dtds_slot_unit #(
  parameter int WINDOW_SLOTS = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            go,
  input  wire logic [dtds_pkg::ID_W-1:0]       id,
  input  wire logic [3:0]                      slot_bits,
  output logic                                 done,
  output logic [$clog2(WINDOW_SLOTS)-1:0]      slot
);
  import dtds_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int RED_K  = $clog2(MASKED_SPAN / WINDOW_SLOTS);
  localparam int K_W    = $clog2(RED_K + 2);

  logic [3:0]          eff_bits;
  logic [MASKED_W-1:0] mask_v;
  logic [MASKED_W-1:0] masked;
  logic [15:0]         rem;
  logic [15:0]         divisor;
  logic [K_W-1:0]      k;
  logic                running;

  always_comb begin
    if (slot_bits == 4'd0) begin
      eff_bits = 4'd1;
    end else if (slot_bits > MAX_SLOT_BITS) begin
      eff_bits = MAX_SLOT_BITS;
    end else begin
      eff_bits = slot_bits;
    end
    mask_v  = MASKED_W'((15'd1 << eff_bits) - 15'd1);
    masked  = id[MASKED_W-1:0] & mask_v;
    divisor = 16'(WINDOW_SLOTS) << k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem     <= 16'(masked);
        k       <= K_W'(RED_K);
        running <= 1'b1;
      end else if (running) begin
        if (rem >= divisor) begin
          rem <= rem - divisor;
        end
        if (k == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
  end

  assign slot = rem[SLOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/dataflow_task_dependency_scheduler.sv =====
// ----------------------------------------------------------------------------
// Dataflow task dependency scheduler
// Task graph scheduler with fan-in reference counts and two ready FIFOs.
// ----------------------------------------------------------------------------
// Load task pays one slot fold; dispatch, dependent loads and unknown commands return
//   their beat without one. Complete adds a slot fold and table reads per dependents-list
//   entry walked, and start clears all WINDOW_SLOTS arrival counters and then folds and
//   reads once per task, stopping early once both FIFOs are full and overflow is set.
//   The block takes one item at a time and is busy until its beat.
// Reset: synchronous; the arrival counters are then cleared with busy high. The receiver
//   cannot stall results.
`default_nettype none

module dataflow_task_dependency_scheduler #(
  parameter int WINDOW_SLOTS = 4096,
  parameter int READY_DEPTH  = 4096,
  parameter int DEP_ENTRIES  = 8192
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  output logic                                 done,
  input  wire logic                            cfg_write,
  input  wire logic [dtds_pkg::CFGIDX_W-1:0]   cfg_index,
  input  wire logic [dtds_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic [2:0]                      command,
  input  wire logic [dtds_pkg::ID_W-1:0]       task_id,
  input  wire logic [dtds_pkg::FANIN_W-1:0]    fanin_total,
  input  wire logic                            worker_kind,
  input  wire logic [dtds_pkg::LINK_W-1:0]     first_dependent,
  input  wire logic [dtds_pkg::LINK_W-1:0]     entry_index,
  input  wire logic [dtds_pkg::ID_W-1:0]       consumer_task,
  input  wire logic [dtds_pkg::LINK_W-1:0]     next_entry,
  input  wire logic                            request_kind,
  output logic                                 granted,
  output logic [dtds_pkg::ID_W-1:0]            granted_task,
  output logic [dtds_pkg::CNTOUT_W-1:0]        cube_ready,
  output logic [dtds_pkg::CNTOUT_W-1:0]        vector_ready,
  output logic [dtds_pkg::ID_W-1:0]            completed_count,
  output logic                                 all_done,
  output logic                                 overflow
);
  import dtds_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int DEP_W  = $clog2(DEP_ENTRIES);
  localparam int STEP_W = $clog2(DEP_ENTRIES + 1);
  localparam int PTR_W  = $clog2(READY_DEPTH);
  localparam int CNT_W  = $clog2(READY_DEPTH + 1);

  // The sequencer. Every command that touches a slot passes through the
  // shared slot unit; all but load task then do a registered read of the descriptor tables.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLEAR = 10'b0000000010,
    S_SLOT  = 10'b0000000100,
    S_TRD   = 10'b0000001000,
    S_TUSE  = 10'b0000010000,
    S_WALK  = 10'b0000100000,
    S_DRD   = 10'b0001000000,
    S_DUSE  = 10'b0010000000,
    S_FRD   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [ID_W-1:0] task_total;
  logic [3:0]      slot_bits;
  logic            graph_built;

  // Fields of the item in flight.
  logic [2:0]         cmd_q;
  logic [ID_W-1:0]    task_id_q;
  logic [FANIN_W-1:0] fanin_q;
  logic               kind_q;
  logic [LINK_W-1:0]  head_q;
  logic               req_kind_q;

  // Sequencer working registers.
  logic [SLOT_W-1:0] clr_idx;
  logic              clr_for_start;
  logic [ID_W-1:0]   loop_idx;
  logic [LINK_W-1:0] cur;
  logic [STEP_W-1:0] steps;
  logic [ID_W-1:0]   cid_q;
  logic [LINK_W-1:0] next_q;
  logic              walking;
  logic [SLOT_W-1:0] slot_q;

  // Status.
  logic [ID_W-1:0] done_tally;
  logic            overflow_flag;
  logic            granted_q;
  logic [ID_W-1:0] granted_task_q;

  // Ready FIFO bookkeeping, index 0 cube and index 1 vector.
  logic [PTR_W-1:0] fifo_head  [2];
  logic [PTR_W-1:0] fifo_tail  [2];
  logic [CNT_W-1:0] fifo_count [2];

  // Memories.
  task_desc_t       tbl_mem  [WINDOW_SLOTS];
  logic [FANIN_W-1:0] cnt_mem [WINDOW_SLOTS];
  dep_entry_t       dep_mem  [DEP_ENTRIES];
  logic [ID_W-1:0]  cube_mem [READY_DEPTH];
  logic [ID_W-1:0]  vec_mem  [READY_DEPTH];

  task_desc_t         tbl_q;
  logic [FANIN_W-1:0] cnt_q;
  dep_entry_t         dep_q;
  logic [ID_W-1:0]    cube_q;
  logic [ID_W-1:0]    vec_q;

  // Slot unit hookup.
  logic              slot_go;
  logic [ID_W-1:0]   slot_id;
  logic              slot_done;
  logic [SLOT_W-1:0] slot_out;

  // Combinational control of the memory ports.
  logic              accept;
  logic              tbl_we;
  logic              cnt_we;
  logic [SLOT_W-1:0] cnt_waddr;
  logic [FANIN_W-1:0] cnt_wdata;
  logic              dep_we;
  logic              push_en;
  logic              push_kind;
  logic [ID_W-1:0]   push_id;
  logic              push_full;
  logic              walk_go;
  logic [ID_W-1:0]   loop_next;

  // Occupancy and overflow as they stand once this cycle's push is done.
  logic [CNT_W-1:0]  cube_after;
  logic [CNT_W-1:0]  vec_after;
  logic              start_stop;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign loop_next = loop_idx + 1'b1;
  assign walk_go   = (cur != '0) &&
                     ({4'd0, cur} < 17'(DEP_ENTRIES)) &&
                     (steps < STEP_W'(DEP_ENTRIES));
  assign push_full = (fifo_count[push_kind] >= CNT_W'(READY_DEPTH));

  dtds_slot_unit #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_slot (
    .clk       (clk),
    .rst       (rst),
    .go        (slot_go),
    .id        (slot_id),
    .slot_bits (slot_bits),
    .done      (slot_done),
    .slot      (slot_out)
  );

  // Once overflow is set and both FIFOs are full, every later enqueue of the
  // start scan would only be dropped, so the scan ends there.
  always_comb begin
    cube_after = fifo_count[0];
    vec_after  = fifo_count[1];
    if (push_en && !push_full) begin
      if (push_kind == KIND_CUBE) begin
        cube_after = fifo_count[0] + 1'b1;
      end else begin
        vec_after = fifo_count[1] + 1'b1;
      end
    end
    start_stop = (overflow_flag || (push_en && push_full)) &&
                 (cube_after >= CNT_W'(READY_DEPTH)) &&
                 (vec_after >= CNT_W'(READY_DEPTH));
  end

  // Which id the slot unit folds, and when it starts.
  always_comb begin
    slot_go = 1'b0;
    slot_id = task_id_q;
    case (state)
      S_IDLE: begin
        slot_go = accept && (command == CMD_LOAD_TASK || command == CMD_COMPLETE);
        slot_id = task_id;
      end
      S_CLEAR: begin
        slot_go = clr_for_start && (clr_idx == SLOT_W'(WINDOW_SLOTS - 1)) &&
                  (task_total != '0);
        slot_id = '0;
      end
      S_TUSE: begin
        slot_go = (cmd_q == CMD_START) && (loop_next < task_total) && !start_stop;
        slot_id = loop_next;
      end
      S_DUSE: begin
        slot_go = 1'b1;
        slot_id = dep_q.consumer;
      end
      default: begin
        slot_go = 1'b0;
        slot_id = task_id_q;
      end
    endcase
  end

  // Memory write controls and ready FIFO pushes.
  always_comb begin
    tbl_we    = (state == S_SLOT) && slot_done && (cmd_q == CMD_LOAD_TASK);
    dep_we    = accept && (command == CMD_LOAD_DEP) &&
                ({4'd0, entry_index} < 17'(DEP_ENTRIES));
    cnt_we    = 1'b0;
    cnt_waddr = slot_q;
    cnt_wdata = cnt_q + 1'b1;
    push_en   = 1'b0;
    push_kind = tbl_q.kind;
    push_id   = cid_q;
    if (state == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx;
      cnt_wdata = '0;
    end else if (state == S_TUSE) begin
      if (cmd_q == CMD_START) begin
        push_en = (tbl_q.fanin == '0);
        push_id = loop_idx;
      end else if (cmd_q == CMD_COMPLETE && walking && cnt_q != '1) begin
        // Arrival counters saturate at their top value.
        cnt_we  = 1'b1;
        push_en = (cnt_wdata == tbl_q.fanin);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[slot_out] <= '{fanin: fanin_q, kind: kind_q, head: head_q};
    end
    tbl_q <= tbl_mem[slot_q];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[slot_q];
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[DEP_W'(entry_index)] <= '{consumer: consumer_task, next: next_entry};
    end
    dep_q <= dep_mem[DEP_W'(cur)];
  end

  always_ff @(posedge clk) begin
    if (push_en && !push_full && push_kind == KIND_CUBE) begin
      cube_mem[fifo_tail[0]] <= push_id;
    end
    cube_q <= cube_mem[fifo_head[0]];
  end

  always_ff @(posedge clk) begin
    if (push_en && !push_full && push_kind == KIND_VECTOR) begin
      vec_mem[fifo_tail[1]] <= push_id;
    end
    vec_q <= vec_mem[fifo_head[1]];
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      task_total  <= '0;
      slot_bits   <= 4'd12;
      graph_built <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TASK_TOTAL:  task_total  <= cfg_data;
        REG_SLOT_BITS:   slot_bits   <= cfg_data[3:0];
        REG_GRAPH_BUILT: graph_built <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Main sequencer, FIFO pointers and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_idx        <= '0;
      clr_for_start  <= 1'b0;
      done_tally     <= '0;
      overflow_flag  <= 1'b0;
      granted_q      <= 1'b0;
      granted_task_q <= '0;
      walking        <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        fifo_head[k]  <= '0;
        fifo_tail[k]  <= '0;
        fifo_count[k] <= '0;
      end
    end else begin
      if (push_en) begin
        if (push_full) begin
          overflow_flag <= 1'b1;
        end else begin
          fifo_tail[push_kind] <= (fifo_tail[push_kind] == PTR_W'(READY_DEPTH - 1)) ?
                                  '0 : fifo_tail[push_kind] + 1'b1;
          fifo_count[push_kind] <= fifo_count[push_kind] + 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q          <= command;
            task_id_q      <= task_id;
            fanin_q        <= fanin_total;
            kind_q         <= worker_kind;
            head_q         <= first_dependent;
            req_kind_q     <= request_kind;
            granted_q      <= 1'b0;
            granted_task_q <= '0;
            walking        <= 1'b0;
            steps          <= '0;
            loop_idx       <= '0;
            case (command)
              CMD_LOAD_TASK, CMD_COMPLETE: begin
                state <= S_SLOT;
              end
              CMD_START: begin
                // Start empties the FIFOs and the tally; overflow stays.
                for (int k = 0; k < 2; k++) begin
                  fifo_head[k]  <= '0;
                  fifo_tail[k]  <= '0;
                  fifo_count[k] <= '0;
                end
                done_tally    <= '0;
                clr_idx       <= '0;
                clr_for_start <= 1'b1;
                state         <= S_CLEAR;
              end
              CMD_DISPATCH: begin
                state <= (fifo_count[request_kind] != '0) ? S_FRD : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SLOT_W'(WINDOW_SLOTS - 1)) begin
            if (!clr_for_start) begin
              state <= S_IDLE;
            end else begin
              clr_for_start <= 1'b0;
              state         <= (task_total != '0) ? S_SLOT : S_DONE;
            end
          end
        end

        S_SLOT: begin
          if (slot_done) begin
            slot_q <= slot_out;
            state  <= (cmd_q == CMD_LOAD_TASK) ? S_DONE : S_TRD;
          end
        end

        S_TRD: begin
          state <= S_TUSE;
        end

        S_TUSE: begin
          if (cmd_q == CMD_START) begin
            loop_idx <= loop_next;
            state    <= ((loop_next < task_total) && !start_stop) ? S_SLOT : S_DONE;
          end else if (!walking) begin
            walking <= 1'b1;
            cur     <= tbl_q.head;
            state   <= S_WALK;
          end else begin
            cur   <= next_q;
            steps <= steps + 1'b1;
            state <= S_WALK;
          end
        end

        S_WALK: begin
          if (walk_go) begin
            state <= S_DRD;
          end else begin
            if (done_tally != '1) begin
              done_tally <= done_tally + 1'b1;
            end
            state <= S_DONE;
          end
        end

        S_DRD: begin
          state <= S_DUSE;
        end

        S_DUSE: begin
          cid_q  <= dep_q.consumer;
          next_q <= dep_q.next;
          state  <= S_SLOT;
        end

        S_FRD: begin
          granted_q      <= 1'b1;
          granted_task_q <= (req_kind_q == KIND_CUBE) ? cube_q : vec_q;
          fifo_head[req_kind_q] <= (fifo_head[req_kind_q] == PTR_W'(READY_DEPTH - 1)) ?
                                   '0 : fifo_head[req_kind_q] + 1'b1;
          fifo_count[req_kind_q] <= fifo_count[req_kind_q] - 1'b1;
          state <= S_DONE;
        end

        S_DONE: begin
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result beat is shown for the single cycle spent in the done state.
  assign done            = (state == S_DONE);
  assign granted         = granted_q;
  assign granted_task    = granted_task_q;
  assign cube_ready      = CNTOUT_W'(fifo_count[0]);
  assign vector_ready    = CNTOUT_W'(fifo_count[1]);
  assign completed_count = done_tally;
  assign all_done        = (done_tally >= task_total) && graph_built;
  assign overflow        = overflow_flag;

  // A result beat lasts exactly one cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat held longer than one cycle");

  // An accepted item keeps the block busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not hold the block busy");

  // FIFO occupancy never passes the depth.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count[0] <= CNT_W'(READY_DEPTH) && fifo_count[1] <= CNT_W'(READY_DEPTH))
    else $error("ready FIFO count exceeds depth");

  // Overflow is raised only by a push that found its FIFO full.
  a_overflow_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow_flag) |-> $past(push_en && push_full))
    else $error("overflow set without a dropped push");

  // A grant only comes from a dispatch command.
  a_grant_cmd: assert property (@(posedge clk) disable iff (rst)
    (done && granted_q) |-> (cmd_q == CMD_DISPATCH))
    else $error("grant on a command other than dispatch");

endmodule

`default_nettype wire

// ===== sim/tb_dataflow_task_dependency_scheduler.sv =====
// ----------------------------------------------------------------------------
// Testbench for the dataflow task dependency scheduler
// Builds small task graphs, starts them, completes tasks and dispatches work
// under random start gaps. The expected status of every beat is worked out by
// an in-bench model of the scheduler and is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dataflow_task_dependency_scheduler;
  import dtds_pkg::*;

  localparam int WINDOW  = 4096;
  localparam int FIFO_SZ = 4096;
  localparam int POOL    = 8192;
  localparam int CYCLE_LIMIT = 4000000;
  // Commands above dispatch are not decoded; the block only reports status.
  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
  // Random walks longer than this are kept out of the random traffic.
  localparam int RANDOM_WALK_CAP = 64;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [ID_W-1:0]    task_id;
    logic [FANIN_W-1:0] fanin;
    logic               kind;
    logic [LINK_W-1:0]  head;
    logic [LINK_W-1:0]  entry;
    logic [ID_W-1:0]    consumer;
    logic [LINK_W-1:0]  nxt;
    logic               req;
  } sched_cmd_t;

  typedef struct packed {
    logic                granted;
    logic [ID_W-1:0]     task_out;
    logic [CNTOUT_W-1:0] cube;
    logic [CNTOUT_W-1:0] vec;
    logic [ID_W-1:0]     completed;
    logic                all_done;
    logic                ovf;
  } sched_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic cfg_write = 1'b0;
  logic [CFGIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic [2:0] command = '0;
  logic [ID_W-1:0] task_id = '0;
  logic [FANIN_W-1:0] fanin_total = '0;
  logic worker_kind = 1'b0;
  logic [LINK_W-1:0] first_dependent = '0;
  logic [LINK_W-1:0] entry_index = '0;
  logic [ID_W-1:0] consumer_task = '0;
  logic [LINK_W-1:0] next_entry = '0;
  logic request_kind = 1'b0;
  logic granted;
  logic [ID_W-1:0] granted_task;
  logic [CNTOUT_W-1:0] cube_ready, vector_ready;
  logic [ID_W-1:0] completed_count;
  logic all_done, overflow;

  dataflow_task_dependency_scheduler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .command(command), .task_id(task_id), .fanin_total(fanin_total),
    .worker_kind(worker_kind), .first_dependent(first_dependent),
    .entry_index(entry_index), .consumer_task(consumer_task), .next_entry(next_entry),
    .request_kind(request_kind), .granted(granted), .granted_task(granted_task),
    .cube_ready(cube_ready), .vector_ready(vector_ready),
    .completed_count(completed_count), .all_done(all_done), .overflow(overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scheduler model. The tables mirror the block's storage; the written flags
  // let the stimulus avoid reading any descriptor or entry that was never
  // loaded, since those contents are undefined in the hardware.
  // --------------------------------------------------------------------------
  logic [23:0] mdl_task_total;
  logic [3:0]  mdl_slot_bits;
  logic        mdl_graph_built;
  logic [15:0] fanin_tab [WINDOW];
  logic        kind_tab  [WINDOW];
  logic [12:0] head_tab  [WINDOW];
  logic [15:0] arrivals  [WINDOW];
  bit          desc_ok   [WINDOW];
  logic [23:0] ent_consumer [POOL];
  logic [12:0] ent_nxt      [POOL];
  bit          ent_ok       [POOL];
  logic [23:0] ready_mem [2][FIFO_SZ];
  int unsigned rd_ptr [2];
  int unsigned wr_ptr [2];
  int unsigned ready_cnt [2];
  logic [23:0] done_tally;
  logic        ovf_flag;

  sched_cmd_t    pending_cmds [$];
  sched_status_t expected_status [$];

  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int grants_seen = 0;
  int cycles = 0;

  function automatic int unsigned window_slot(logic [23:0] id);
    int unsigned b;
    b = mdl_slot_bits;
    if (b < 1) b = 1;
    if (b > 14) b = 14;
    return (int'(id) & ((1 << b) - 1)) % WINDOW;
  endfunction

  function automatic void ready_push(logic k, logic [23:0] id);
    if (ready_cnt[k] >= FIFO_SZ) begin
      ovf_flag = 1'b1;
      return;
    end
    ready_mem[k][wr_ptr[k]] = id;
    wr_ptr[k] = (wr_ptr[k] + 1) % FIFO_SZ;
    ready_cnt[k]++;
  endfunction

  function automatic sched_status_t predict_status(sched_cmd_t c);
    sched_status_t r;
    int unsigned s, cur, steps, cs;
    r = '0;
    case (c.cmd)
      CMD_LOAD_TASK: begin
        s = window_slot(c.task_id);
        fanin_tab[s] = c.fanin;
        kind_tab[s] = c.kind;
        head_tab[s] = c.head;
        desc_ok[s] = 1'b1;
      end
      CMD_LOAD_DEP: begin
        ent_consumer[c.entry] = c.consumer;
        ent_nxt[c.entry] = c.nxt;
        ent_ok[c.entry] = 1'b1;
      end
      CMD_START: begin
        for (int i = 0; i < WINDOW; i++) arrivals[i] = '0;
        for (int k = 0; k < 2; k++) begin
          rd_ptr[k] = 0;
          wr_ptr[k] = 0;
          ready_cnt[k] = 0;
        end
        done_tally = '0;
        for (int unsigned i = 0; i < mdl_task_total; i++) begin
          s = window_slot(24'(i));
          if (fanin_tab[s] == 0) ready_push(kind_tab[s], 24'(i));
          // Once both FIFOs are full nothing more can be queued.
          if (ovf_flag && ready_cnt[0] >= FIFO_SZ && ready_cnt[1] >= FIFO_SZ) break;
        end
      end
      CMD_COMPLETE: begin
        cur = head_tab[window_slot(c.task_id)];
        steps = 0;
        while (cur != 0 && steps < POOL) begin
          cs = window_slot(ent_consumer[cur]);
          if (arrivals[cs] != 16'hFFFF) begin
            arrivals[cs] = arrivals[cs] + 16'd1;
            if (arrivals[cs] == fanin_tab[cs]) ready_push(kind_tab[cs], ent_consumer[cur]);
          end
          cur = ent_nxt[cur];
          steps++;
        end
        if (done_tally != 24'hFFFFFF) done_tally++;
      end
      CMD_DISPATCH: begin
        if (ready_cnt[c.req] > 0) begin
          r.granted = 1'b1;
          r.task_out = ready_mem[c.req][rd_ptr[c.req]];
          rd_ptr[c.req] = (rd_ptr[c.req] + 1) % FIFO_SZ;
          ready_cnt[c.req]--;
        end
      end
      default: ;
    endcase
    r.cube = CNTOUT_W'(ready_cnt[0]);
    r.vec = CNTOUT_W'(ready_cnt[1]);
    r.completed = done_tally;
    r.all_done = (done_tally >= mdl_task_total) && mdl_graph_built;
    r.ovf = ovf_flag;
    return r;
  endfunction

  // Start reads the descriptor of every task below the total; the slot map
  // repeats every 16384 ids, so checking that many ids is enough.
  function automatic bit start_is_safe();
    int unsigned n;
    n = (mdl_task_total < MASKED_SPAN) ? mdl_task_total : MASKED_SPAN;
    for (int unsigned i = 0; i < n; i++)
      if (!desc_ok[window_slot(24'(i))]) return 1'b0;
    return 1'b1;
  endfunction

  // Length of the dependents walk for a completion, or -1 when it would touch
  // a descriptor or entry that was never loaded.
  function automatic int walk_length(logic [23:0] id);
    int unsigned s, cur, steps;
    s = window_slot(id);
    if (!desc_ok[s]) return -1;
    cur = head_tab[s];
    steps = 0;
    while (cur != 0 && steps < POOL) begin
      if (!ent_ok[cur] || !desc_ok[window_slot(ent_consumer[cur])]) return -1;
      cur = ent_nxt[cur];
      steps++;
    end
    return steps;
  endfunction

  task automatic queue_beat(sched_cmd_t c);
    expected_status.push_back(predict_status(c));
    pending_cmds.push_back(c);
  endtask

  function automatic sched_cmd_t blank_cmd(logic [2:0] op);
    sched_cmd_t c;
    c = '0;
    c.cmd = op;
    return c;
  endfunction

  // Ids that mostly land in the low slots, where the graphs are built.
  function automatic logic [23:0] near_id();
    logic [23:0] r;
    r = 24'($urandom);
    if ($urandom_range(0, 99) < 85) r[11:0] = 12'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic logic [12:0] pool_link();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return '0;
    if (p < 90) return 13'($urandom_range(1, 31));
    return 13'($urandom);
  endfunction

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int p;
    logic [23:0] id;
    c.task_id = ID_W'($urandom);
    c.fanin = FANIN_W'($urandom);
    c.kind = 1'($urandom);
    c.head = LINK_W'($urandom);
    c.entry = LINK_W'($urandom);
    c.consumer = ID_W'($urandom);
    c.nxt = LINK_W'($urandom);
    c.req = 1'($urandom);
    p = $urandom_range(0, 99);
    if (p < 15) begin
      c.cmd = CMD_LOAD_TASK;
      c.task_id = near_id();
      if ($urandom_range(0, 99) < 70) c.fanin = FANIN_W'($urandom_range(0, 3));
      c.head = pool_link();
    end else if (p < 30) begin
      c.cmd = CMD_LOAD_DEP;
      if ($urandom_range(0, 99) < 85) c.entry = LINK_W'($urandom_range(1, 31));
      c.consumer = near_id();
      c.nxt = pool_link();
    end else if (p < 33) begin
      c.cmd = start_is_safe() ? CMD_START : CMD_DISPATCH;
    end else if (p < 70) begin
      c.cmd = CMD_DISPATCH;
      for (int t = 0; t < 8; t++) begin
        id = near_id();
        if (walk_length(id) >= 0 && walk_length(id) <= RANDOM_WALK_CAP) begin
          c.cmd = CMD_COMPLETE;
          c.task_id = id;
          break;
        end
      end
    end else if (p < 96) begin
      c.cmd = CMD_DISPATCH;
    end else begin
      c.cmd = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
    end
    return c;
  endfunction

  task automatic queue_load_task(logic [23:0] id, logic [15:0] fi, logic k, logic [12:0] hd);
    sched_cmd_t c;
    c = blank_cmd(CMD_LOAD_TASK);
    c.task_id = id;
    c.fanin = fi;
    c.kind = k;
    c.head = hd;
    queue_beat(c);
  endtask

  task automatic queue_load_dep(logic [12:0] e, logic [23:0] cid, logic [12:0] nx);
    sched_cmd_t c;
    c = blank_cmd(CMD_LOAD_DEP);
    c.entry = e;
    c.consumer = cid;
    c.nxt = nx;
    queue_beat(c);
  endtask

  task automatic queue_complete(logic [23:0] id);
    sched_cmd_t c;
    c = blank_cmd(CMD_COMPLETE);
    c.task_id = id;
    queue_beat(c);
  endtask

  task automatic queue_dispatch(logic k);
    sched_cmd_t c;
    c = blank_cmd(CMD_DISPATCH);
    c.req = k;
    queue_beat(c);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) queue_beat(random_cmd());
  endtask

  // Registers are written only with the block idle, so the model is updated
  // at the same point.
  task automatic write_reg(logic [CFGIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_TASK_TOTAL:  mdl_task_total = val;
      REG_SLOT_BITS:   mdl_slot_bits = val[3:0];
      REG_GRAPH_BUILT: mdl_graph_built = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [23:0] total, logic [3:0] sbits, logic built);
    write_reg(REG_TASK_TOTAL, total);
    write_reg(REG_SLOT_BITS, {20'd0, sbits});
    write_reg(REG_GRAPH_BUILT, {23'd0, built});
  endtask

  // The sender holds off here until every expected status beat is back.
  task automatic drain();
    while (pending_cmds.size() != 0 || expected_status.size() != 0 || start)
      @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: one command beat at a time, with random gaps between beats.
  // Long stretches run back to back when the steady mode is on.
  // --------------------------------------------------------------------------
  int gap_left = 0;
  int next_gap;
  bit steady = 1'b0;

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic present_beat(sched_cmd_t c);
    start <= 1'b1;
    command <= c.cmd;
    task_id <= c.task_id;
    fanin_total <= c.fanin;
    worker_kind <= c.kind;
    first_dependent <= c.head;
    entry_index <= c.entry;
    consumer_task <= c.consumer;
    next_entry <= c.nxt;
    request_kind <= c.req;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      beats_in++;
      if ($urandom_range(0, 99) < 2) steady = !steady;
      next_gap = steady ? 0 : pick_gap();
      if (next_gap == 0 && pending_cmds.size() != 0) begin
        present_beat(pending_cmds.pop_front());
      end else begin
        start <= 1'b0;
        gap_left <= next_gap;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        present_beat(pending_cmds.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every done strobe carries one status beat, checked against the
  // oldest expectation.
  // --------------------------------------------------------------------------
  sched_status_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      beats_out++;
      if (granted) grants_seen++;
      if (expected_status.size() == 0) begin
        $error("status beat with nothing expected");
        errors++;
      end else begin
        want = expected_status.pop_front();
        if (granted !== want.granted) begin
          $error("granted: expected %0h, got %0h", want.granted, granted);
          errors++;
        end
        if (granted_task !== want.task_out) begin
          $error("granted_task: expected %0h, got %0h", want.task_out, granted_task);
          errors++;
        end
        if (cube_ready !== want.cube) begin
          $error("cube_ready: expected %0d, got %0d", want.cube, cube_ready);
          errors++;
        end
        if (vector_ready !== want.vec) begin
          $error("vector_ready: expected %0d, got %0d", want.vec, vector_ready);
          errors++;
        end
        if (completed_count !== want.completed) begin
          $error("completed_count: expected %0d, got %0d", want.completed, completed_count);
          errors++;
        end
        if (all_done !== want.all_done) begin
          $error("all_done: expected %0h, got %0h", want.all_done, all_done);
          errors++;
        end
        if (overflow !== want.ovf) begin
          $error("overflow: expected %0h, got %0h", want.ovf, overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_dataflow_task_dependency_scheduler: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus phases.
  // --------------------------------------------------------------------------
  initial begin
    mdl_task_total = '0;
    mdl_slot_bits = 4'd12;
    mdl_graph_built = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      arrivals[i] = '0;
      desc_ok[i] = 1'b0;
    end
    for (int i = 0; i < POOL; i++) ent_ok[i] = 1'b0;
    for (int k = 0; k < 2; k++) begin
      rd_ptr[k] = 0;
      wr_ptr[k] = 0;
      ready_cnt[k] = 0;
    end
    done_tally = '0;
    ovf_flag = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // After reset the block clears its counters with busy high.
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed graph: three roots, a join with fan-in two, a task that can never
    // become ready, a task id with every bit set, and a consumer that lies
    // outside the started range.
    configure(24'd6, 4'd4, 1'b1);
    queue_load_task(24'h000000, 16'd0, KIND_CUBE, 13'd1);
    queue_load_task(24'hABC001, 16'd0, KIND_VECTOR, 13'd2);
    queue_load_task(24'h000002, 16'd2, KIND_CUBE, 13'd0);
    queue_load_task(24'h123453, 16'd1, KIND_VECTOR, 13'd0);
    queue_load_task(24'h000004, 16'hFFFF, KIND_VECTOR, 13'd0);
    queue_load_task(24'hFFFFF5, 16'd0, KIND_CUBE, 13'h1FFF);
    queue_load_task(24'hFFFFFF, 16'd1, KIND_VECTOR, 13'd0);
    queue_load_dep(13'd1, 24'h000002, 13'd3);
    queue_load_dep(13'd3, 24'hFFFFF3, 13'd0);
    queue_load_dep(13'd2, 24'h000002, 13'd0);
    queue_load_dep(13'h1FFF, 24'hFFFFFF, 13'd0);
    queue_beat(blank_cmd(CMD_START));
    queue_dispatch(KIND_CUBE);
    queue_dispatch(KIND_VECTOR);
    queue_dispatch(KIND_VECTOR);
    queue_complete(24'h000000);
    queue_complete(24'hABC001);
    queue_dispatch(KIND_CUBE);
    queue_dispatch(KIND_VECTOR);
    queue_beat(blank_cmd(CMD_UNKNOWN_LO));
    queue_beat(blank_cmd(CMD_UNKNOWN_HI));
    queue_complete(24'hFFFFF5);
    queue_dispatch(KIND_CUBE);
    queue_random(300);
    drain();

    configure(24'd0, 4'd1, 1'b0);
    queue_random(150);
    drain();

    configure(24'd10, 4'd15, 1'b1);
    queue_random(200);
    drain();

    configure(24'd5, 4'd12, 1'b0);
    queue_beat(blank_cmd(CMD_START));
    queue_random(200);
    drain();

    // A dependents list that points back at itself: every walk stops after
    // the pool size, and the consumer's arrival count runs into saturation.
    configure(24'd0, 4'd13, 1'b1);
    configure(24'd0, 4'd4, 1'b1);
    queue_load_task(24'hABC005, 16'hFFFF, KIND_VECTOR, 13'd0);
    queue_load_task(24'h000006, 16'd1, KIND_CUBE, 13'd100);
    queue_load_dep(13'd100, 24'hFEDCB5, 13'd100);
    queue_beat(blank_cmd(CMD_START));
    for (int i = 0; i < 8; i++) queue_complete(24'h000006);
    queue_dispatch(KIND_VECTOR);
    queue_dispatch(KIND_VECTOR);
    drain();

    // Largest task total with a two-slot window: both ready FIFOs fill up and
    // the next enqueue is dropped and flagged.
    configure(24'hFFFFFF, 4'd0, 1'b1);
    queue_load_task(24'h000000, 16'd0, KIND_CUBE, 13'd0);
    queue_load_task(24'h000001, 16'd0, KIND_VECTOR, 13'd0);
    queue_beat(blank_cmd(CMD_START));
    queue_dispatch(KIND_CUBE);
    queue_dispatch(KIND_VECTOR);
    queue_complete(24'h000000);
    queue_dispatch(KIND_VECTOR);
    drain();

    $display("Covered %0d command beats and %0d status beats, %0d of them grants,",
             beats_in, beats_out, grants_seen);
    $display("across six register settings including a saturated walk and full FIFOs.");
    if (errors == 0) begin
      $display("tb_dataflow_task_dependency_scheduler: done, clean");
    end else begin
      $display("tb_dataflow_task_dependency_scheduler: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
